>>> rtl/segint_pkg.sv
// shared constants for the segment pair intersection block
package segint_pkg;

    // contact classes of a result item
    localparam logic [1:0] CONTACT_NONE    = 2'd0;
    localparam logic [1:0] CONTACT_CROSS   = 2'd1;
    localparam logic [1:0] CONTACT_OVERLAP = 2'd2;
    localparam logic [1:0] CONTACT_BAD     = 2'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // result item layout
    localparam int CROSS_BITS = 32;
    localparam int OUT_W      = 72;

endpackage

>>> rtl/segint_fifo.sv
// small register queue between the front and back parts
module segint_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int CNT_BITS = segint_pkg::QPTR_BITS + 1;

    logic [WIDTH-1:0]                  mem_reg [0:segint_pkg::QUEUE_DEPTH-1];
    logic [segint_pkg::QPTR_BITS-1:0]  wptr_reg, rptr_reg;
    logic [CNT_BITS-1:0]               cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_BITS'(segint_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

>>> rtl/segint_front.sv
// front part: differences, cross products and classification of each item
module segint_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [8*COORD_BITS-1:0] in_data,
    output logic                    push,
    input  logic                    full,
    output logic [1:0]              q_contact,
    output logic [COORD_BITS-1:0]   q_ax,
    output logic [COORD_BITS-1:0]   q_ay,
    output logic [COORD_BITS:0]     q_adx,
    output logic [COORD_BITS:0]     q_ady,
    output logic [2*COORD_BITS+1:0] q_den,
    output logic [2*COORD_BITS+1:0] q_tn
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2*C + 2;
    localparam int SW = 2*C + 3;

    logic fen;

    // input coordinates
    logic signed [C-1:0] ax, ay, ax2, ay2, bx, by, bx2, by2;
    assign ax  = in_data[0*C +: C];
    assign ay  = in_data[1*C +: C];
    assign ax2 = in_data[2*C +: C];
    assign ay2 = in_data[3*C +: C];
    assign bx  = in_data[4*C +: C];
    assign by  = in_data[5*C +: C];
    assign bx2 = in_data[6*C +: C];
    assign by2 = in_data[7*C +: C];

    // stage one logic: direction vectors and axis tests
    logic signed [C:0]   adx, ady, bdx, bdy, ex, ey;
    logic signed [C:0]   sax, sbx, say, sby;
    logic signed [C+1:0] dsx, dsy;
    logic [C+1:0]        mdsx, mdsy, wx, wy;
    logic [C:0]          madx, mady, mbdx, mbdy;
    logic                av, bv, ah, bh, ovx, ovy;
    logic                decided;
    logic [1:0]          early;

    always_comb
    begin
        adx = (C+1)'(ax2) - (C+1)'(ax);
        ady = (C+1)'(ay2) - (C+1)'(ay);
        bdx = (C+1)'(bx2) - (C+1)'(bx);
        bdy = (C+1)'(by2) - (C+1)'(by);
        ex  = (C+1)'(bx) - (C+1)'(ax);
        ey  = (C+1)'(by) - (C+1)'(ay);
        sax = (C+1)'(ax) + (C+1)'(ax2);
        sbx = (C+1)'(bx) + (C+1)'(bx2);
        say = (C+1)'(ay) + (C+1)'(ay2);
        sby = (C+1)'(by) + (C+1)'(by2);
        dsx = (C+2)'(sax) - (C+2)'(sbx);
        dsy = (C+2)'(say) - (C+2)'(sby);
        mdsx = dsx[C+1] ? (C+2)'(-dsx) : (C+2)'(dsx);
        mdsy = dsy[C+1] ? (C+2)'(-dsy) : (C+2)'(dsy);
        madx = adx[C] ? (C+1)'(-adx) : (C+1)'(adx);
        mady = ady[C] ? (C+1)'(-ady) : (C+1)'(ady);
        mbdx = bdx[C] ? (C+1)'(-bdx) : (C+1)'(bdx);
        mbdy = bdy[C] ? (C+1)'(-bdy) : (C+1)'(bdy);
        wx  = (C+2)'(madx) + (C+2)'(mbdx);
        wy  = (C+2)'(mady) + (C+2)'(mbdy);
        ovx = mdsx < wx;
        ovy = mdsy < wy;
        av  = (adx == '0);
        bv  = (bdx == '0);
        ah  = !av && (ady == '0);
        bh  = !bv && (bdy == '0);
        decided = 1'b0;
        early   = segint_pkg::CONTACT_NONE;
        if (ah && bh)
        begin
            decided = 1'b1;
            if (ay == by && ovx)
            begin
                early = segint_pkg::CONTACT_OVERLAP;
            end
        end
        else if (av && bv)
        begin
            decided = 1'b1;
            if (ax == bx && ovy)
            begin
                early = segint_pkg::CONTACT_OVERLAP;
            end
        end
        else if ((av && ady == '0) || (bv && bdy == '0))
        begin
            decided = 1'b1;
        end
    end

    // stage one registers
    logic                s1_valid_reg;
    logic signed [C-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [C:0]   s1_adx_reg, s1_ady_reg, s1_bdx_reg, s1_bdy_reg, s1_ex_reg, s1_ey_reg;
    logic                s1_dec_reg, s1_ovx_reg;
    logic [1:0]          s1_early_reg;

    // stage two registers: cross products
    logic                 s2_valid_reg;
    logic signed [C-1:0]  s2_ax_reg, s2_ay_reg;
    logic signed [C:0]    s2_adx_reg, s2_ady_reg;
    logic signed [PW-1:0] s2_pd1_reg, s2_pd2_reg, s2_pt1_reg, s2_pt2_reg;
    logic signed [PW-1:0] s2_pu1_reg, s2_pu2_reg;
    logic                 s2_dec_reg, s2_ovx_reg;
    logic [1:0]           s2_early_reg;

    assign fen      = !(s2_valid_reg && full);
    assign in_ready = fen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (fen)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            s1_ax_reg    <= ax;
            s1_ay_reg    <= ay;
            s1_adx_reg   <= adx;
            s1_ady_reg   <= ady;
            s1_bdx_reg   <= bdx;
            s1_bdy_reg   <= bdy;
            s1_ex_reg    <= ex;
            s1_ey_reg    <= ey;
            s1_dec_reg   <= decided;
            s1_ovx_reg   <= ovx;
            s1_early_reg <= early;
            s2_ax_reg    <= s1_ax_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_adx_reg   <= s1_adx_reg;
            s2_ady_reg   <= s1_ady_reg;
            s2_pd1_reg   <= PW'(s1_adx_reg * s1_bdy_reg);
            s2_pd2_reg   <= PW'(s1_ady_reg * s1_bdx_reg);
            s2_pt1_reg   <= PW'(s1_ex_reg * s1_bdy_reg);
            s2_pt2_reg   <= PW'(s1_ey_reg * s1_bdx_reg);
            s2_pu1_reg   <= PW'(s1_ex_reg * s1_ady_reg);
            s2_pu2_reg   <= PW'(s1_ey_reg * s1_adx_reg);
            s2_dec_reg   <= s1_dec_reg;
            s2_ovx_reg   <= s1_ovx_reg;
            s2_early_reg <= s1_early_reg;
        end
    end

    // classification of the crossing from the products
    logic signed [SW-1:0] den, tn, un, dm, tnn, unn;
    logic                 hit;

    always_comb
    begin
        den = SW'(s2_pd1_reg) - SW'(s2_pd2_reg);
        tn  = SW'(s2_pt1_reg) - SW'(s2_pt2_reg);
        un  = SW'(s2_pu1_reg) - SW'(s2_pu2_reg);
        dm  = den[SW-1] ? -den : den;
        tnn = den[SW-1] ? -tn : tn;
        unn = den[SW-1] ? -un : un;
        hit = (tnn > 0) && (tnn < dm) && (unn > 0) && (unn < dm);
        if (s2_dec_reg)
        begin
            q_contact = s2_early_reg;
        end
        else if (den == '0)
        begin
            q_contact = (un == '0 && s2_ovx_reg) ? segint_pkg::CONTACT_OVERLAP
                                                  : segint_pkg::CONTACT_NONE;
        end
        else
        begin
            q_contact = hit ? segint_pkg::CONTACT_CROSS : segint_pkg::CONTACT_NONE;
        end
    end

    assign push  = s2_valid_reg && !full;
    assign q_ax  = s2_ax_reg;
    assign q_ay  = s2_ay_reg;
    assign q_adx = s2_adx_reg;
    assign q_ady = s2_ady_reg;
    assign q_den = dm[PW-1:0];
    assign q_tn  = tnn[PW-1:0];

endmodule

>>> rtl/segint_back.sv
// back part: crossing point numerators and pipelined rounding division
module segint_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    output logic                        pop,
    input  logic [1:0]                  q_contact,
    input  logic [COORD_BITS-1:0]       q_ax,
    input  logic [COORD_BITS-1:0]       q_ay,
    input  logic [COORD_BITS:0]         q_adx,
    input  logic [COORD_BITS:0]         q_ady,
    input  logic [2*COORD_BITS+1:0]     q_den,
    input  logic [2*COORD_BITS+1:0]     q_tn,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_contact,
    output logic [31:0]                 out_x,
    output logic [31:0]                 out_y
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DENW = 2*C + 2;
    localparam int NW   = 3*C + 5;
    localparam int NPW  = NW + F + 1;
    localparam int Q    = C + F + 1;
    localparam int DW   = 2*C + 4;
    localparam int RW   = Q + 34;
    localparam logic signed [RW-1:0] BIAS = RW'(1) <<< (C - 1 + F);
    localparam logic signed [RW-1:0] MAXV = (RW'(1) <<< 31) - RW'(1);
    localparam logic signed [RW-1:0] MINV = -(RW'(1) <<< 31);

    logic en;
    logic out_valid_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !empty;

    // stage b1: four products for the numerators
    logic                 b1_valid_reg;
    logic [1:0]           b1_contact_reg;
    logic [DENW-1:0]      b1_den_reg;
    logic signed [NW-1:0] b1_px0_reg, b1_px1_reg, b1_py0_reg, b1_py1_reg;
    logic signed [DENW:0] den_s, tn_s;

    assign den_s = {1'b0, q_den};
    assign tn_s  = {1'b0, q_tn};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_contact_reg <= q_contact;
            b1_den_reg     <= q_den;
            b1_px0_reg     <= NW'($signed(q_ax) * den_s);
            b1_px1_reg     <= NW'($signed(q_adx) * tn_s);
            b1_py0_reg     <= NW'($signed(q_ay) * den_s);
            b1_py1_reg     <= NW'($signed(q_ady) * tn_s);
        end
    end

    // stage b2: biased numerators, shifted and with the half added
    logic signed [NW-1:0] denw, numx, numy;
    logic [NPW-1:0]       npx, npy;

    always_comb
    begin
        denw = {{(NW-DENW){1'b0}}, b1_den_reg};
        numx = b1_px0_reg + b1_px1_reg + (denw <<< (C - 1));
        numy = b1_py0_reg + b1_py1_reg + (denw <<< (C - 1));
        npx  = {numx, {(F+1){1'b0}}} + NPW'(b1_den_reg);
        npy  = {numy, {(F+1){1'b0}}} + NPW'(b1_den_reg);
    end

    // divider stages, index zero loaded from b2
    logic          vld_reg     [0:Q];
    logic [1:0]    con_reg     [0:Q];
    logic [DW-1:0] d2_reg      [0:Q];
    logic [DW-1:0] remx_reg    [0:Q];
    logic [DW-1:0] remy_reg    [0:Q];
    logic [Q-1:0]  lowx_reg    [0:Q];
    logic [Q-1:0]  lowy_reg    [0:Q];
    logic [Q-1:0]  quox_reg    [0:Q];
    logic [Q-1:0]  quoy_reg    [0:Q];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            vld_reg[0]   <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= pop;
            vld_reg[0]   <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            con_reg[0]  <= b1_contact_reg;
            d2_reg[0]   <= DW'({b1_den_reg, 1'b0});
            remx_reg[0] <= npx[Q +: DW];
            remy_reg[0] <= npy[Q +: DW];
            lowx_reg[0] <= npx[Q-1:0];
            lowy_reg[0] <= npy[Q-1:0];
            quox_reg[0] <= '0;
            quoy_reg[0] <= '0;
        end
    end

    genvar i;
    generate
        for (i = 1; i <= Q; i++)
        begin : g_div
            logic [DW-1:0] sx, sy;
            logic          gx, gy;

            // one quotient bit per stage for each coordinate
            always_comb
            begin
                sx = {remx_reg[i-1][DW-2:0], lowx_reg[i-1][Q-1]};
                sy = {remy_reg[i-1][DW-2:0], lowy_reg[i-1][Q-1]};
                gx = sx >= d2_reg[i-1];
                gy = sy >= d2_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    con_reg[i]  <= con_reg[i-1];
                    d2_reg[i]   <= d2_reg[i-1];
                    remx_reg[i] <= gx ? sx - d2_reg[i-1] : sx;
                    remy_reg[i] <= gy ? sy - d2_reg[i-1] : sy;
                    lowx_reg[i] <= {lowx_reg[i-1][Q-2:0], 1'b0};
                    lowy_reg[i] <= {lowy_reg[i-1][Q-2:0], 1'b0};
                    quox_reg[i] <= {quox_reg[i-1][Q-2:0], gx};
                    quoy_reg[i] <= {quoy_reg[i-1][Q-2:0], gy};
                end
            end
        end
    endgenerate

    // remove bias and clamp to the signed 32-bit range; zero the point unless a crossing
    logic signed [RW-1:0] vx, vy;
    logic [31:0]          cx, cy;

    always_comb
    begin
        vx = $signed({{(RW-Q){1'b0}}, quox_reg[Q]}) - BIAS;
        vy = $signed({{(RW-Q){1'b0}}, quoy_reg[Q]}) - BIAS;
        cx = (vx > MAXV) ? MAXV[31:0] : (vx < MINV) ? MINV[31:0] : vx[31:0];
        cy = (vy > MAXV) ? MAXV[31:0] : (vy < MINV) ? MINV[31:0] : vy[31:0];
        if (con_reg[Q] != segint_pkg::CONTACT_CROSS)
        begin
            cx = '0;
            cy = '0;
        end
    end

    // output register
    logic [1:0]  out_contact_reg;
    logic [31:0] out_x_reg, out_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_contact_reg <= con_reg[Q];
            out_x_reg       <= cx;
            out_y_reg       <= cy;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_contact = out_contact_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;

`ifndef SYNTHESIS
    // a point is only reported for a crossing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_contact_reg != segint_pkg::CONTACT_CROSS
        |-> out_x_reg == '0 && out_y_reg == '0)
        else $error("crossing point set without a crossing");

    // no result carries the unused contact code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_contact_reg != segint_pkg::CONTACT_BAD)
        else $error("unused contact code");

    // an item taken from the queue enters the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> b1_valid_reg)
        else $error("popped item lost");
`endif

endmodule

>>> rtl/segment_pair_intersection.sv
// top level of the segment pair intersection block
//
//  channel  dir  fields (lowest bit up)
//  s_*      in   a_x1 a_y1 a_x2 a_y2 b_x1 b_y1 b_x2 b_y2, COORD_BITS each
//  m_*      out  contact[1:0] cross_x[33:2] cross_y[65:34], zero fill to 72
//
// one item per cycle while the output is not stalled; an item passes front stages one and two,
// the queue, then back stage b1, the bit-per-stage divider and the output register
// reset clears all valid flags and the queue; payload registers are not reset
// a stalled output freezes the back pipeline; the four-entry queue lets the
// front keep accepting until it fills
module segment_pair_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [8*COORD_BITS-1:0]         s_tdata,  // a_x1 a_y1 a_x2 a_y2 b_x1 b_y1 b_x2 b_y2
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [segint_pkg::OUT_W-1:0]    m_tdata   // contact cross_x cross_y
);

    localparam int C  = COORD_BITS;
    localparam int EW = 2 + C + C + (C+1) + (C+1) + 2*(2*C+2);

    logic                push, full, pop, empty;
    logic [1:0]          f_contact, b_contact;
    logic [C-1:0]        f_ax, f_ay, b_ax, b_ay;
    logic [C:0]          f_adx, f_ady, b_adx, b_ady;
    logic [2*C+1:0]      f_den, f_tn, b_den, b_tn;
    logic [EW-1:0]       din, dout;
    logic [31:0]         out_x, out_y;
    logic [1:0]          out_contact;

    // front part
    segint_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .push      (push),
        .full      (full),
        .q_contact (f_contact),
        .q_ax      (f_ax),
        .q_ay      (f_ay),
        .q_adx     (f_adx),
        .q_ady     (f_ady),
        .q_den     (f_den),
        .q_tn      (f_tn)
    );

    // queue between the parts
    assign din = {f_tn, f_den, f_ady, f_adx, f_ay, f_ax, f_contact};
    assign {b_tn, b_den, b_ady, b_adx, b_ay, b_ax, b_contact} = dout;

    segint_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (din),
        .full  (full),
        .pop   (pop),
        .dout  (dout),
        .empty (empty)
    );

    // back part
    segint_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .pop         (pop),
        .q_contact   (b_contact),
        .q_ax        (b_ax),
        .q_ay        (b_ay),
        .q_adx       (b_adx),
        .q_ady       (b_ady),
        .q_den       (b_den),
        .q_tn        (b_tn),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_contact (out_contact),
        .out_x       (out_x),
        .out_y       (out_y)
    );

    // result packing
    assign m_tdata = {{(segint_pkg::OUT_W-66){1'b0}}, out_y, out_x, out_contact};

endmodule
